// ===== hdl/bsmh_pkg.sv =====
`timescale 1ns / 1ps

package bsmh_pkg;

  localparam logic [31:0] GOLDEN_INIT = 32'h9e3779b9;
  localparam logic [31:0] C_INIT      = 32'h9b9773e9;

  localparam int          BLOCK_LEN   = 12;
  localparam logic [3:0]  BLOCK_FULL  = 4'(BLOCK_LEN);
  localparam logic [3:0]  LAST_ROUND  = 4'd8;

  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_key;
  } bsmh_in_t;

  typedef struct packed {
    logic [31:0] hash_low;
    logic [31:0] hash_high;
  } bsmh_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } bsmh_words_t;

  // Work handed from the byte collector to the mixing engine.
  typedef struct packed {
    logic        absorb;
    bsmh_words_t blk;
    logic        finish;
    bsmh_words_t tail;
    logic [31:0] key_len;
  } bsmh_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_BLK,
    ST_ADD_TAIL,
    ST_MIX_FIN,
    ST_EMIT
  } bsmh_state_t;

  function automatic bsmh_words_t init_words();
    bsmh_words_t w;
    w.a = GOLDEN_INIT;
    w.b = GOLDEN_INIT;
    w.c = C_INIT;
    return w;
  endfunction

  function automatic bsmh_words_t add_words(bsmh_words_t w, bsmh_words_t v);
    bsmh_words_t r;
    r.a = w.a + v.a;
    r.b = w.b + v.b;
    r.c = w.c + v.c;
    return r;
  endfunction

  // One of the nine rounds of the lookup2 mix; rounds rotate over a, b, c.
  function automatic bsmh_words_t mix_round(bsmh_words_t w, logic [3:0] rnd);
    bsmh_words_t r;
    r = w;
    unique case (rnd)
      4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/bsmh_front.sv =====
`timescale 1ns / 1ps

module bsmh_front
  import bsmh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  bsmh_in_t  in_item,
  input  logic      q_full,
  output logic      job_push,
  output bsmh_job_t job
);

  logic [7:0]  buf_r [BLOCK_LEN];
  logic [7:0]  buf_nxt [BLOCK_LEN];
  logic [7:0]  tb [BLOCK_LEN];
  logic [3:0]  fill_r, fill_nxt, nfill;
  logic [31:0] len_r, len_nxt, nlen;
  logic        accept;

  assign accept = in_push && !q_full;

  always_comb begin
    buf_nxt = buf_r;
    nfill   = fill_r;
    nlen    = len_r;
    job     = '0;

    if (in_item.has_byte) begin
      // A full block is absorbed only once a further byte shows it is not the tail.
      if (fill_r == BLOCK_FULL) begin
        job.absorb = 1'b1;
        job.blk.a  = {buf_r[3], buf_r[2], buf_r[1], buf_r[0]};
        job.blk.b  = {buf_r[7], buf_r[6], buf_r[5], buf_r[4]};
        job.blk.c  = {buf_r[11], buf_r[10], buf_r[9], buf_r[8]};
        buf_nxt[0] = in_item.data_byte;
        nfill      = 4'd1;
      end else begin
        buf_nxt[fill_r] = in_item.data_byte;
        nfill           = fill_r + 4'd1;
      end
      nlen = len_r + 32'd1;
    end

    for (int i = 0; i < BLOCK_LEN; i++) begin
      tb[i] = (4'(i) < nfill) ? buf_nxt[i] : 8'h00;
    end

    if (in_item.end_of_key) begin
      job.finish  = 1'b1;
      job.key_len = nlen;
      if (nfill == BLOCK_FULL) begin
        job.absorb = 1'b1;
        job.blk.a  = {buf_nxt[3], buf_nxt[2], buf_nxt[1], buf_nxt[0]};
        job.blk.b  = {buf_nxt[7], buf_nxt[6], buf_nxt[5], buf_nxt[4]};
        job.blk.c  = {buf_nxt[11], buf_nxt[10], buf_nxt[9], buf_nxt[8]};
      end else begin
        job.tail.a = {tb[3], tb[2], tb[1], tb[0]};
        job.tail.b = {tb[7], tb[6], tb[5], tb[4]};
        job.tail.c = {tb[10], tb[9], tb[8], 8'h00};
      end
    end

    fill_nxt = in_item.end_of_key ? 4'd0 : nfill;
    len_nxt  = in_item.end_of_key ? 32'd0 : nlen;
  end

  assign job_push = accept && (job.absorb || job.finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 4'd0;
      len_r  <= 32'd0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= buf_nxt;
    end
  end

endmodule

// ===== hdl/bsmh_queue.sv =====
`timescale 1ns / 1ps

module bsmh_queue
  import bsmh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bsmh_job_t push_job,
  output logic      full,
  input  logic      pop,
  output bsmh_job_t pop_job,
  output logic      empty
);

  bsmh_job_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/bsmh_back.sv =====
`timescale 1ns / 1ps

module bsmh_back
  import bsmh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  bsmh_job_t q_job,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output bsmh_out_t out_result
);

  bsmh_state_t state_r, state_nxt;
  bsmh_words_t words_r, words_nxt, tail_sum;
  bsmh_job_t   job_r, job_nxt;
  logic [3:0]  step_r, step_nxt;
  bsmh_out_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free, last_round;

  assign out_free   = !out_valid_r || out_pop;
  assign last_round = (step_r == LAST_ROUND);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_job.absorb ? ST_MIX_BLK : ST_MIX_FIN;
        end
      end
      ST_MIX_BLK: begin
        if (last_round) begin
          state_nxt = job_r.finish ? ST_ADD_TAIL : ST_IDLE;
        end
      end
      ST_ADD_TAIL: state_nxt = ST_MIX_FIN;
      ST_MIX_FIN: begin
        if (last_round) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    words_nxt     = words_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    tail_sum      = '0;

    unique case (state_r) inside
      ST_IDLE: begin
        step_nxt = 4'd0;
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          if (q_job.absorb) begin
            words_nxt = add_words(words_r, q_job.blk);
          end else begin
            tail_sum     = q_job.tail;
            tail_sum.c   = q_job.tail.c + q_job.key_len;
            words_nxt    = add_words(words_r, tail_sum);
          end
        end
      end
      ST_MIX_BLK, ST_MIX_FIN: begin
        words_nxt = mix_round(words_r, step_r);
        step_nxt  = last_round ? 4'd0 : step_r + 4'd1;
      end
      ST_ADD_TAIL: begin
        tail_sum   = job_r.tail;
        tail_sum.c = job_r.tail.c + job_r.key_len;
        words_nxt  = add_words(words_r, tail_sum);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_nxt.hash_low  = words_r.c;
          out_nxt.hash_high = words_r.a;
          out_valid_nxt     = 1'b1;
          words_nxt         = init_words();
        end
      end
      default: begin
        words_nxt = words_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      words_r     <= init_words();
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      words_r     <= words_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  assign out_empty  = !out_valid_r;
  assign out_result = out_r;

endmodule

// ===== hdl/byte_stream_mix_hash_core.sv =====
`timescale 1ns / 1ps

// Lookup2 hash of a byte stream, one key byte per beat. The input side takes
// a beat every cycle while the four-entry job queue has room; bytes collect
// in a 12-byte block register and each full block becomes one job for the
// mixing engine, which adds the block and then runs the nine mix rounds, so
// the engine keeps up with a full byte rate. At the end of a key the engine
// does the add, nine rounds and the hand-off to the output register, and it
// first adds and mixes a full block when the final job also carries one,
// which happens when the key ends on a full block or on the byte right after
// one. A result is held up further when earlier blocks or results are still
// ahead of it. Runs of very short keys therefore fill the job queue, and
// in_full holds off the input until it drains.
// hash_low is the 32-bit hash and hash_high carries the final a word of the
// mix. The next key may stream in while earlier results are still being
// mixed or wait to be popped.
module byte_stream_mix_hash_core
  import bsmh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  bsmh_in_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output bsmh_out_t out_result
);

  logic      q_full, q_empty, q_pop, job_push;
  bsmh_job_t job_in, job_out;

  bsmh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job_in)
  );

  bsmh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (job_out),
    .empty    (q_empty)
  );

  bsmh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (job_out),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

  assign in_full = q_full;

endmodule

// ===== hdl/bsmh_checker.sv =====
`timescale 1ns / 1ps

module bsmh_checker
  import bsmh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input bsmh_in_t  in_item,
  input logic      out_empty,
  input logic      out_pop,
  input bsmh_out_t out_result
);

  logic [3:0] keys_r;
  logic       end_beat, out_beat;

  assign end_beat = in_push && !in_full && in_item.end_of_key;
  assign out_beat = out_pop && !out_empty;

  // Keys whose final beat went in and whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= 4'd0;
    end else if (end_beat && !out_beat) begin
      keys_r <= keys_r + 4'd1;
    end else if (out_beat && !end_beat) begin
      keys_r <= keys_r - 4'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queue flags not cleared by reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> keys_r != 4'd0)
    else $error("result shown without a finished key");

  a_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (end_beat && keys_r == 4'd0) |=> out_empty)
    else $error("result appeared before mixing could finish");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_result))
    else $error("waiting result changed or vanished");

endmodule

bind byte_stream_mix_hash_core bsmh_checker u_bsmh_checker (.*);
